// ----- src/hce_pkg.sv -----
package hce_pkg;

    localparam int BUFFER_BYTES = 32;
    localparam int CHUNK_CAP    = (BUFFER_BYTES < 32) ? BUFFER_BYTES : 32;
    localparam int IDX_W        = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int FILL_W       = 6;
    localparam int PC_W         = 6;

    localparam logic [FILL_W-1:0] CHUNK_SIZE_RESET = FILL_W'(32);

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_FLUSH = 2'd1;
    localparam logic [1:0] FUNC_CLOSE = 2'd2;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_LF   = 8'h0a;

    // program entry points and jump targets
    localparam logic [PC_W-1:0] ENT_WRITE = PC_W'(0);
    localparam logic [PC_W-1:0] W_HEXLO   = PC_W'(3);
    localparam logic [PC_W-1:0] W_STORE   = PC_W'(9);
    localparam logic [PC_W-1:0] ENT_FLUSH = PC_W'(10);
    localparam logic [PC_W-1:0] F_HEXLO   = PC_W'(13);
    localparam logic [PC_W-1:0] F_DONE    = PC_W'(19);
    localparam logic [PC_W-1:0] ENT_CLOSE = PC_W'(20);
    localparam logic [PC_W-1:0] C_HEXLO   = PC_W'(23);
    localparam logic [PC_W-1:0] C_TERM    = PC_W'(29);

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_HEXHI,
        SEL_HEXLO,
        SEL_CR,
        SEL_LF,
        SEL_ZERO,
        SEL_DATA
    } sel_t;

    typedef enum logic [1:0] {
        JC_NEVER,
        JC_FILL_LT_EFF,
        JC_FILL_LT_16,
        JC_FILL_ZERO
    } jcond_t;

    typedef struct packed {
        sel_t            sel;
        jcond_t          jc;
        logic [PC_W-1:0] tgt;
        logic            loop;
        logic            last;
        logic            clr_fill;
        logic            store;
        logic            fin;
    } uword_t;

    typedef struct packed {
        logic fill_lt_eff;
        logic fill_lt_16;
        logic fill_zero;
        logic ptr_last;
    } cond_t;

    typedef struct packed {
        logic fire;
        sel_t sel;
        logic last;
        logic clr_fill;
        logic store;
        logic ptr_inc;
    } exec_t;

    function automatic uword_t mk(sel_t sel, jcond_t jc, logic [PC_W-1:0] tgt,
                                  logic loop, logic last, logic clr_fill,
                                  logic store, logic fin);
        uword_t w;
        w.sel      = sel;
        w.jc       = jc;
        w.tgt      = tgt;
        w.loop     = loop;
        w.last     = last;
        w.clr_fill = clr_fill;
        w.store    = store;
        w.fin      = fin;
        return w;
    endfunction

    // control store
    function automatic uword_t ucode(logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            // write
            PC_W'(0):  w = mk(SEL_NONE,  JC_FILL_LT_EFF, W_STORE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(1):  w = mk(SEL_NONE,  JC_FILL_LT_16,  W_HEXLO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(2):  w = mk(SEL_HEXHI, JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(3):  w = mk(SEL_HEXLO, JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(4):  w = mk(SEL_CR,    JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(5):  w = mk(SEL_LF,    JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(6):  w = mk(SEL_DATA,  JC_NEVER, '0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(7):  w = mk(SEL_CR,    JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(8):  w = mk(SEL_LF,    JC_NEVER, '0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
            PC_W'(9):  w = mk(SEL_NONE,  JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
            // flush
            PC_W'(10): w = mk(SEL_NONE,  JC_FILL_ZERO,  F_DONE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(11): w = mk(SEL_NONE,  JC_FILL_LT_16, F_HEXLO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(12): w = mk(SEL_HEXHI, JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(13): w = mk(SEL_HEXLO, JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(14): w = mk(SEL_CR,    JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(15): w = mk(SEL_LF,    JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(16): w = mk(SEL_DATA,  JC_NEVER, '0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(17): w = mk(SEL_CR,    JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(18): w = mk(SEL_LF,    JC_NEVER, '0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
            PC_W'(19): w = mk(SEL_NONE,  JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            // close
            PC_W'(20): w = mk(SEL_NONE,  JC_FILL_ZERO,  C_TERM,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(21): w = mk(SEL_NONE,  JC_FILL_LT_16, C_HEXLO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(22): w = mk(SEL_HEXHI, JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(23): w = mk(SEL_HEXLO, JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(24): w = mk(SEL_CR,    JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(25): w = mk(SEL_LF,    JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(26): w = mk(SEL_DATA,  JC_NEVER, '0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(27): w = mk(SEL_CR,    JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(28): w = mk(SEL_LF,    JC_NEVER, '0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
            PC_W'(29): w = mk(SEL_ZERO,  JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(30): w = mk(SEL_CR,    JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(31): w = mk(SEL_LF,    JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(32): w = mk(SEL_CR,    JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            PC_W'(33): w = mk(SEL_LF,    JC_NEVER, '0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
            default:   w = mk(SEL_NONE,  JC_NEVER, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        endcase
        return w;
    endfunction

    function automatic logic [7:0] hex_digit(logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
        begin
            r = CHAR_ZERO + {4'h0, v};
        end
        else
        begin
            r = CHAR_LA + {4'h0, v - 4'd10};
        end
        return r;
    endfunction

endpackage

// ----- src/hce_mem.sv -----
module hce_mem (
    input  logic                      clk,
    input  logic                      we,
    input  logic [hce_pkg::IDX_W-1:0] waddr,
    input  logic [7:0]                wdata,
    input  logic [hce_pkg::IDX_W-1:0] raddr,
    output logic [7:0]                rdata
);

    logic [7:0] mem [hce_pkg::BUFFER_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/hce_seq.sv -----
module hce_seq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [hce_pkg::PC_W-1:0] entry,
    input  hce_pkg::cond_t           cond,
    input  logic                     slot_free,
    output logic                     busy,
    output hce_pkg::exec_t           ex
);

    logic [hce_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                     busy_reg, busy_next;
    hce_pkg::uword_t          w;
    logic                     jtake;
    logic                     step;
    logic                     hold;

    assign w = hce_pkg::ucode(pc_reg);

    always_comb
    begin
        case (w.jc)
            hce_pkg::JC_FILL_LT_EFF: jtake = cond.fill_lt_eff;
            hce_pkg::JC_FILL_LT_16:  jtake = cond.fill_lt_16;
            hce_pkg::JC_FILL_ZERO:   jtake = cond.fill_zero;
            default:                 jtake = 1'b0;
        endcase
        jtake = jtake && busy_reg;
    end

    assign step = busy_reg && !jtake && ((w.sel == hce_pkg::SEL_NONE) || slot_free);
    assign hold = w.loop && !cond.ptr_last;

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            pc_next   = entry;
            busy_next = 1'b1;
        end
        else if (jtake)
        begin
            pc_next = w.tgt;
        end
        else if (step && !hold)
        begin
            if (w.fin)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    assign busy        = busy_reg;
    assign ex.fire     = step && (w.sel != hce_pkg::SEL_NONE);
    assign ex.sel      = w.sel;
    assign ex.last     = w.last;
    assign ex.clr_fill = step && w.clr_fill;
    assign ex.store    = step && w.store;
    assign ex.ptr_inc  = step && hold;

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !ex.fire && !ex.store && !ex.clr_fill)
        else $error("sequencer acts while idle");

endmodule

// ----- src/http_chunked_encoder.sv -----
// HTTP/1.1 chunked transfer encoder.
// Input channel (in_valid/in_ready) carries one item: func and data_byte.
// func write buffers a byte; if the store already holds a full chunk, that
// chunk (hex length, CRLF, data, CRLF) is sent first. flush sends a held
// chunk, close sends a held chunk then "0" CRLF CRLF. func 3 is dropped.
// Output channel (out_valid/out_ready) gives one byte per item, with
// last_of_run on the final byte caused by an input item.
// cfg_we/cfg_wdata write chunk_size (0 acts as 1, large values clamp).
// One item is worked at a time by a microcoded sequencer; in_ready is high
// only while it is idle. An item that sends a chunk gives its data one byte
// per cycle, while the receiver is not stalled, from the data loop over the
// chunk store's single read port. Close adds 5 bytes.
// A stalled receiver holds the output register and the sequencer waits on
// it; no byte is lost. Reset empties the store, clears the output and sets
// chunk_size to 32; the store contents need no clearing.
module http_chunked_encoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [hce_pkg::FILL_W-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 func,
    input  logic [7:0]                 data_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_byte,
    output logic                       last_of_run
);

    logic [hce_pkg::FILL_W-1:0] chunk_size_reg;
    logic [hce_pkg::FILL_W-1:0] fill_count_reg, fill_count_next;
    logic [hce_pkg::IDX_W-1:0]  ptr_reg, ptr_next;
    logic [7:0]                 data_reg;
    logic                       out_valid_reg;
    logic [7:0]                 out_byte_reg;
    logic                       last_reg;

    logic [hce_pkg::FILL_W-1:0] eff_size;
    logic [hce_pkg::PC_W-1:0]   entry;
    logic                       accept;
    logic                       start;
    logic                       busy;
    logic                       slot_free;
    logic [7:0]                 rdata;
    logic [7:0]                 emit_byte;
    hce_pkg::cond_t             cond;
    hce_pkg::exec_t             ex;

    assign in_ready  = !busy;
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (func)
            hce_pkg::FUNC_WRITE: entry = hce_pkg::ENT_WRITE;
            hce_pkg::FUNC_FLUSH: entry = hce_pkg::ENT_FLUSH;
            hce_pkg::FUNC_CLOSE: entry = hce_pkg::ENT_CLOSE;
            default:             entry = hce_pkg::ENT_WRITE;
        endcase
    end

    assign start = accept && (func == hce_pkg::FUNC_WRITE || func == hce_pkg::FUNC_FLUSH
                              || func == hce_pkg::FUNC_CLOSE);

    always_comb
    begin
        if (chunk_size_reg == '0)
        begin
            eff_size = hce_pkg::FILL_W'(1);
        end
        else if (chunk_size_reg > hce_pkg::FILL_W'(hce_pkg::CHUNK_CAP))
        begin
            eff_size = hce_pkg::FILL_W'(hce_pkg::CHUNK_CAP);
        end
        else
        begin
            eff_size = chunk_size_reg;
        end
    end

    assign cond.fill_lt_eff = fill_count_reg < eff_size;
    assign cond.fill_lt_16  = fill_count_reg < hce_pkg::FILL_W'(16);
    assign cond.fill_zero   = fill_count_reg == '0;
    assign cond.ptr_last    = (hce_pkg::FILL_W'(ptr_reg) + 1'b1) == fill_count_reg;

    hce_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .entry     (entry),
        .cond      (cond),
        .slot_free (slot_free),
        .busy      (busy),
        .ex        (ex)
    );

    // read address is ptr_next, so the registered rdata always matches ptr_reg
    always_comb
    begin
        ptr_next = ptr_reg;
        if (start)
        begin
            ptr_next = '0;
        end
        else if (ex.ptr_inc)
        begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    hce_mem u_mem (
        .clk   (clk),
        .we    (ex.store),
        .waddr (fill_count_reg[hce_pkg::IDX_W-1:0]),
        .wdata (data_reg),
        .raddr (ptr_next),
        .rdata (rdata)
    );

    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (ex.clr_fill)
        begin
            fill_count_next = '0;
        end
        else if (ex.store)
        begin
            fill_count_next = fill_count_reg + 1'b1;
        end
    end

    always_comb
    begin
        case (ex.sel)
            hce_pkg::SEL_HEXHI: emit_byte = hce_pkg::hex_digit({2'b00, fill_count_reg[5:4]});
            hce_pkg::SEL_HEXLO: emit_byte = hce_pkg::hex_digit(fill_count_reg[3:0]);
            hce_pkg::SEL_CR:    emit_byte = hce_pkg::CHAR_CR;
            hce_pkg::SEL_LF:    emit_byte = hce_pkg::CHAR_LF;
            hce_pkg::SEL_ZERO:  emit_byte = hce_pkg::CHAR_ZERO;
            hce_pkg::SEL_DATA:  emit_byte = rdata;
            default:            emit_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_size_reg <= hce_pkg::CHUNK_SIZE_RESET;
            fill_count_reg <= '0;
            ptr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                chunk_size_reg <= cfg_wdata;
            end
            fill_count_reg <= fill_count_next;
            ptr_reg        <= ptr_next;
            if (ex.fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_byte;
        end
        if (ex.fire)
        begin
            out_byte_reg <= emit_byte;
            last_reg     <= ex.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= hce_pkg::FILL_W'(hce_pkg::BUFFER_BYTES))
        else $error("fill count beyond store depth");

    a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
        ex.store |-> fill_count_reg < hce_pkg::FILL_W'(hce_pkg::BUFFER_BYTES))
        else $error("store into full buffer");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ex.ptr_inc |-> (hce_pkg::FILL_W'(ptr_reg) + 1'b1) < fill_count_reg)
        else $error("data pointer past fill count");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        ex.fire |-> slot_free)
        else $error("output register overwritten");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !in_ready)
        else $error("item accepted but sequencer not busy");

endmodule
